// File: rtl/gshare_predictor_with_btb_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the branch predictor
// Shorthand for clocked implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GSHARE_PREDICTOR_WITH_BTB_ASSERT_SVH
`define GSHARE_PREDICTOR_WITH_BTB_ASSERT_SVH

// same-cycle implication
`define GSB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("predictor check failed");

// next-cycle implication
`define GSB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("predictor check failed");

`endif

// File: rtl/gshbtb_pkg.sv
// ----------------------------------------------------------------------------
// gshbtb_pkg
// Sizes, codes and helpers for the gshare predictor with target buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package gshbtb_pkg;

  localparam int BTB_ENTRIES = 1024;
  localparam int PHT_ENTRIES = 256;
  localparam int BTB_AW      = $clog2(BTB_ENTRIES);
  localparam int PHT_AW      = $clog2(PHT_ENTRIES);
  localparam int CLR_DEPTH   = (BTB_ENTRIES > PHT_ENTRIES) ? BTB_ENTRIES : PHT_ENTRIES;
  localparam int CLR_AW      = $clog2(CLR_DEPTH);
  localparam int HIST_W      = 8;
  localparam int CTR_W       = 2;

  localparam logic [31:0]      INSN_BYTES = 32'd4;
  localparam logic [CTR_W-1:0] CTR_MAX    = 2'd3;
  localparam logic [CTR_W-1:0] CTR_TAKEN  = 2'd2;
  localparam logic [CTR_W-1:0] CTR_MIN    = 2'd0;

  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_RESOLVE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  typedef struct packed {
    logic        valid;
    logic        is_cond;
    logic [31:0] tag;
    logic [31:0] target;
  } btb_entry_t;

  function automatic logic [PHT_AW-1:0] pht_index(input logic [31:0] pc,
                                                   input logic [HIST_W-1:0] hist);
    logic [31:0] mix;
    mix = (pc >> 2) ^ 32'(hist);
    return mix[PHT_AW-1:0];
  endfunction

  function automatic logic [CTR_W-1:0] ctr_step(input logic [CTR_W-1:0] ctr,
                                                input logic taken);
    logic [CTR_W-1:0] res;
    res = ctr;
    if (taken) begin
      if (ctr != CTR_MAX) res = ctr + CTR_W'(1);
    end else begin
      if (ctr != CTR_MIN) res = ctr - CTR_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/gshare_predictor_with_btb.sv
// out_valid rises when a request leaves ST_LOOK, entered on acceptance with the
// table reads registered; ST_LOOK waits while an earlier result is held with
// out_ready low. A new request is accepted only in ST_IDLE; the memory read and
// the update/write-back of each request are serialized on the memory ports.
// Reset: after rst the block sweeps both tables, one entry per cycle, for
// CLR_DEPTH addresses (1024 at default sizes) with in_ready low.
// ----------------------------------------------------------------------------
// gshare_predictor_with_btb
// Direct-mapped target buffer plus gshare counter table; predicts and resolves.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gshare_predictor_with_btb_assert.svh"

module gshare_predictor_with_btb (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [31:0] pc,
  input  wire logic        is_cond,
  input  wire logic        taken,
  input  wire logic [31:0] target,
  input  wire logic        guess_taken,
  input  wire logic [31:0] guess_next,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             pred_taken,
  output logic [31:0]      pred_next_pc,
  output logic             mispredict,
  output logic [31:0]      redirect_pc
);

  gshbtb_pkg::state_t state, state_next;

  gshbtb_pkg::btb_entry_t btb_mem [gshbtb_pkg::BTB_ENTRIES];
  logic [gshbtb_pkg::CTR_W-1:0] pht_mem [gshbtb_pkg::PHT_ENTRIES];

  gshbtb_pkg::btb_entry_t       btb_rd;
  logic [gshbtb_pkg::CTR_W-1:0] pht_rd;

  logic [gshbtb_pkg::CLR_AW-1:0] clr_cnt;
  logic [gshbtb_pkg::HIST_W-1:0] hist;

  logic                          req_cmd;
  logic [31:0]                   req_pc;
  logic                          req_is_cond;
  logic                          req_taken;
  logic [31:0]                   req_target;
  logic                          req_guess_taken;
  logic [31:0]                   req_guess_next;
  logic [gshbtb_pkg::PHT_AW-1:0] req_pht_idx;

  logic                          accept;
  logic                          adv;
  logic                          clearing;
  logic                          hit;
  logic                          pt;
  logic [31:0]                   seq;
  logic [31:0]                   dest;
  logic                          mis;
  logic                          btb_we;
  logic [gshbtb_pkg::BTB_AW-1:0] btb_wa;
  gshbtb_pkg::btb_entry_t        btb_wd;
  logic                          pht_we;
  logic [gshbtb_pkg::PHT_AW-1:0] pht_wa;
  logic [gshbtb_pkg::CTR_W-1:0]  pht_wd;

  assign clearing = (state == gshbtb_pkg::ST_CLEAR);
  assign in_ready = (state == gshbtb_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign adv      = (state == gshbtb_pkg::ST_LOOK) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      gshbtb_pkg::ST_CLEAR: begin
        if (clr_cnt == gshbtb_pkg::CLR_AW'(gshbtb_pkg::CLR_DEPTH - 1))
          state_next = gshbtb_pkg::ST_IDLE;
      end
      gshbtb_pkg::ST_IDLE: begin
        if (accept) state_next = gshbtb_pkg::ST_LOOK;
      end
      gshbtb_pkg::ST_LOOK: begin
        if (adv) state_next = gshbtb_pkg::ST_IDLE;
      end
      default: state_next = gshbtb_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= gshbtb_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr_cnt <= clr_cnt + gshbtb_pkg::CLR_AW'(1);
    end
  end

  // capture request and issue table reads
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd         <= cmd;
      req_pc          <= pc;
      req_is_cond     <= is_cond;
      req_taken       <= taken;
      req_target      <= target;
      req_guess_taken <= guess_taken;
      req_guess_next  <= guess_next;
      req_pht_idx     <= gshbtb_pkg::pht_index(pc, hist);
      btb_rd          <= btb_mem[pc[gshbtb_pkg::BTB_AW+1:2]];
      pht_rd          <= pht_mem[gshbtb_pkg::pht_index(pc, hist)];
    end
  end

  always_comb begin
    seq  = req_pc + gshbtb_pkg::INSN_BYTES;
    hit  = btb_rd.valid && (btb_rd.tag == req_pc);
    pt   = hit && (!btb_rd.is_cond || (pht_rd >= gshbtb_pkg::CTR_TAKEN));
    dest = req_taken ? req_target : seq;
    mis  = (req_guess_taken != req_taken) || (req_guess_next != dest) || !btb_rd.valid;
  end

  always_comb begin
    btb_we = clearing || (adv && (req_cmd == gshbtb_pkg::CMD_RESOLVE));
    pht_we = clearing || (adv && (req_cmd == gshbtb_pkg::CMD_RESOLVE) && req_is_cond);
    if (clearing) begin
      btb_wa = clr_cnt[gshbtb_pkg::BTB_AW-1:0];
      btb_wd = '0;
      pht_wa = clr_cnt[gshbtb_pkg::PHT_AW-1:0];
      pht_wd = gshbtb_pkg::CTR_MIN;
    end else begin
      btb_wa         = req_pc[gshbtb_pkg::BTB_AW+1:2];
      btb_wd.valid   = 1'b1;
      btb_wd.is_cond = req_is_cond;
      btb_wd.tag     = req_pc;
      btb_wd.target  = req_target;
      pht_wa         = req_pht_idx;
      pht_wd         = gshbtb_pkg::ctr_step(pht_rd, req_taken);
    end
  end

  always_ff @(posedge clk) begin
    if (btb_we) btb_mem[btb_wa] <= btb_wd;
  end

  always_ff @(posedge clk) begin
    if (pht_we) pht_mem[pht_wa] <= pht_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (adv && (req_cmd == gshbtb_pkg::CMD_RESOLVE)) begin
      hist <= {hist[gshbtb_pkg::HIST_W-2:0], req_taken};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (req_cmd == gshbtb_pkg::CMD_PREDICT) begin
        pred_taken   <= pt;
        pred_next_pc <= pt ? btb_rd.target : seq;
        mispredict   <= 1'b0;
        redirect_pc  <= '0;
      end else begin
        pred_taken   <= 1'b0;
        pred_next_pc <= '0;
        mispredict   <= mis;
        redirect_pc  <= dest;
      end
    end
  end

  `GSB_ASSERT_NEXT(a_accept_to_look, accept, state == gshbtb_pkg::ST_LOOK)
  `GSB_ASSERT_NEXT(a_adv_gives_result, adv, out_valid)
  `GSB_ASSERT_SAME(a_write_only_when_owned, btb_we, clearing || adv)
  `GSB_ASSERT_NEXT(a_hist_shift, adv && (req_cmd == gshbtb_pkg::CMD_RESOLVE), hist[0] == req_taken)

endmodule

`default_nettype wire
